[hw/rtl/preemptive_priority_scheduler_unit_defines.svh]
// Assertion macros shared by the scheduler RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PPS_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// Next-cycle implication, disabled while reset is high.
`define PPS_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

[hw/rtl/pps_pkg.sv]
// Shared types and constants for the preemptive priority scheduler.
// Used by pps_cell and preemptive_priority_scheduler_unit; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

  localparam int DEFAULT_MAX_TASKS = 16;

  localparam int IDX_W   = 4;   // entry_index / run_index width
  localparam int WORK_W  = 16;  // burst and remaining work width
  localparam int PRI_W   = 8;
  localparam int CLK_W   = 32;
  localparam int TCNT_W  = 5;   // task_count width
  localparam int DONE_W  = 5;
  localparam int SDATA_W = 32;
  localparam int MDATA_W = 104;
  localparam int MUSER_W = 2;

  localparam logic [CLK_W-1:0]  CLOCK_MAX = '1;
  localparam logic [DONE_W-1:0] DONE_MAX  = '1;
  localparam logic [TCNT_W-1:0] TASK_COUNT_RESET = 5'd1;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_OUT
  } state_t;

  // Running best candidate handed from cell to cell.
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [PRI_W-1:0]  pri;
    logic [WORK_W-1:0] rem;
    logic [WORK_W-1:0] burst;
    logic [1:0]        busy;   // entries with work, saturates at 2
  } cand_t;

  // Write / decrement command broadcast to all cells.
  typedef struct packed {
    logic              wr;
    logic              dec;
    logic [IDX_W-1:0]  idx;
    logic [WORK_W-1:0] burst;
    logic [PRI_W-1:0]  pri;
  } cmd_t;

endpackage

`default_nettype wire

[hw/rtl/pps_cell.sv]
// One table entry of the scheduler: remaining work, priority and burst,
// plus one stage of the selection chain. Depends on pps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pps_cell #(
  parameter int CELL_INDEX = 0,
  parameter int SEL_W      = 4
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_use,
  input  pps_pkg::cmd_t           cmd,
  input  wire  [SEL_W-1:0]        dec_idx,
  input  pps_pkg::cand_t          cand_in,
  input  wire  [SEL_W-1:0]        pick_in,
  output pps_pkg::cand_t          cand_out,
  output logic [SEL_W-1:0]        pick_out
);
  import pps_pkg::*;

  logic [WORK_W-1:0] rem;
  logic [PRI_W-1:0]  pri;
  logic [WORK_W-1:0] burst;
  cand_t             cand_q;
  logic [SEL_W-1:0]  pick_q;

  logic  has_work;
  logic  take;
  logic  wr_hit;
  logic  dec_hit;
  cand_t cand_next;

  assign has_work = in_use && (rem != '0);
  // Strictly greater keeps ties on the lower index.
  assign take     = has_work && (!cand_in.found || (pri > cand_in.pri));
  assign wr_hit   = cmd.wr && (32'(cmd.idx) == 32'(CELL_INDEX));
  assign dec_hit  = cmd.dec && (32'(dec_idx) == 32'(CELL_INDEX));

  always_comb begin
    cand_next       = cand_in;
    cand_next.found = cand_in.found || has_work;
    if (take) begin
      cand_next.pri   = pri;
      cand_next.rem   = rem;
      cand_next.burst = burst;
    end
    if (cand_in.busy == 2'd2) begin
      cand_next.busy = 2'd2;
    end else begin
      cand_next.busy = cand_in.busy + {1'b0, has_work};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem   <= '0;
      pri   <= '0;
      burst <= '0;
    end else if (wr_hit) begin
      rem   <= cmd.burst;
      pri   <= cmd.pri;
      burst <= cmd.burst;
    end else if (dec_hit) begin
      rem <= rem - WORK_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_q.valid <= 1'b0;
    end else begin
      cand_q.valid <= cand_in.valid;
    end
    cand_q.found <= cand_next.found;
    cand_q.pri   <= cand_next.pri;
    cand_q.rem   <= cand_next.rem;
    cand_q.burst <= cand_next.burst;
    cand_q.busy  <= cand_next.busy;
    pick_q       <= take ? SEL_W'(CELL_INDEX) : pick_in;
  end

  assign cand_out = cand_q;
  assign pick_out = pick_q;

endmodule

`default_nettype wire

[hw/rtl/preemptive_priority_scheduler_unit.sv]
// Preemptive priority scheduler: a row of MAX_TASKS entry cells walked by a
// selection token one cell per cycle. A tick passes from accept through the
// MAX_TASKS chain stages to the result/update step; a load first writes the
// entry and then runs the scan that judges all_done. One item is in flight at
// a time; a finished result sits in the output register while the next item is
// taken. Depends on pps_pkg, pps_cell and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

module preemptive_priority_scheduler_unit #(
  parameter int MAX_TASKS = pps_pkg::DEFAULT_MAX_TASKS
) (
  input  wire                          clk,
  input  wire                          rst,
  // config: task_count
  input  wire                          cfg_wr_en,
  input  wire  [pps_pkg::TCNT_W-1:0]   cfg_wr_data,
  // input stream
  input  wire                          s_tvalid,
  output logic                         s_tready,
  // [3:0] entry_index, [19:4] burst_length, [27:20] task_priority, rest zero
  input  wire  [pps_pkg::SDATA_W-1:0]  s_tdata,
  // [0] opcode
  input  wire                          s_tuser,
  // result stream
  output logic                         m_tvalid,
  input  wire                          m_tready,
  // [3:0] run_index, [35:4] turnaround, [67:36] waiting, [68] all_done,
  // [100:69] time_now, rest zero
  output logic [pps_pkg::MDATA_W-1:0]  m_tdata,
  // [0] run_valid, [1] finished
  output logic [pps_pkg::MUSER_W-1:0]  m_tuser
);
  import pps_pkg::*;

  `include "preemptive_priority_scheduler_unit_defines.svh"

  localparam int SEL_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  state_t state, state_next;

  logic [TCNT_W-1:0] task_count;
  logic [CLK_W-1:0]  tick_clock;
  logic [DONE_W-1:0] done_count;

  op_t               op_q;
  logic [IDX_W-1:0]  idx_q;
  logic [WORK_W-1:0] burst_q;
  logic [PRI_W-1:0]  pri_q;
  logic              start;
  cand_t             fin;
  logic [SEL_W-1:0]  fin_pick;

  cand_t             chain [0:MAX_TASKS];
  logic [SEL_W-1:0]  pick_chain [0:MAX_TASKS];
  logic [MAX_TASKS-1:0] use_mask;
  logic [MAX_TASKS-1:0] token_vec;
  cmd_t              cmd;

  logic              accept;
  logic              out_free;
  logic              emit;
  logic              last_valid;
  logic              ran;
  logic              done_now;
  logic [CLK_W-1:0]  fin_time;
  logic [CLK_W-1:0]  wait_time;
  logic              all_done;

  assign accept     = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign last_valid = chain[MAX_TASKS].valid;
  assign s_tready   = (state == S_IDLE);
  assign emit       = (state == S_OUT) && out_free;

  // ---------------- cell row ----------------
  always_comb begin
    chain[0]       = '0;
    chain[0].valid = start;
    pick_chain[0]  = '0;
  end

  assign cmd.wr    = (state == S_LOAD);
  assign cmd.dec   = (state == S_SCAN) && last_valid && (op_q == OP_TICK) &&
                     chain[MAX_TASKS].found;
  assign cmd.idx   = idx_q;
  assign cmd.burst = burst_q;
  assign cmd.pri   = pri_q;

  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
    assign use_mask[g]  = (32'(g) < 32'(task_count));
    assign token_vec[g] = chain[g+1].valid;
    pps_cell #(
      .CELL_INDEX (g),
      .SEL_W      (SEL_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_use   (use_mask[g]),
      .cmd      (cmd),
      .dec_idx  (pick_chain[MAX_TASKS]),
      .cand_in  (chain[g]),
      .pick_in  (pick_chain[g]),
      .cand_out (chain[g+1]),
      .pick_out (pick_chain[g+1])
    );
  end

  // ---------------- control ----------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (op_t'(s_tuser) == OP_TICK) ? S_SCAN : S_LOAD;
        end
      end
      S_LOAD: state_next = S_SCAN;
      S_SCAN: begin
        if (last_valid) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      start <= (accept && (op_t'(s_tuser) == OP_TICK)) || (state == S_LOAD);
    end
  end

  // Hold the accepted item.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= op_t'(s_tuser);
      idx_q   <= s_tdata[3:0];
      burst_q <= s_tdata[19:4];
      pri_q   <= s_tdata[27:20];
    end
  end

  // Capture the chain's final candidate.
  always_ff @(posedge clk) begin
    if ((state == S_SCAN) && last_valid) begin
      fin      <= chain[MAX_TASKS];
      fin_pick <= pick_chain[MAX_TASKS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      task_count <= TASK_COUNT_RESET;
    end else if (cfg_wr_en) begin
      task_count <= cfg_wr_data;
    end
  end

  // ---------------- result ----------------
  assign ran      = (op_q == OP_TICK) && fin.found;
  assign done_now = ran && (fin.rem == WORK_W'(1));
  assign fin_time = (tick_clock == CLOCK_MAX) ? CLOCK_MAX : tick_clock + CLK_W'(1);
  assign wait_time = (fin_time >= CLK_W'(fin.burst)) ? fin_time - CLK_W'(fin.burst)
                                                     : '0;
  // Busy count was taken before the decrement; a lone busy entry that finished
  // leaves nothing.
  assign all_done = (fin.busy == 2'd0) || ((fin.busy == 2'd1) && done_now);

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_clock <= '0;
      done_count <= '0;
    end else if (state == S_LOAD) begin
      tick_clock <= '0;
      done_count <= '0;
    end else if (emit && (op_q == OP_TICK)) begin
      if (tick_clock != CLOCK_MAX) begin
        tick_clock <= tick_clock + CLK_W'(1);
      end
      if (done_now && (done_count != DONE_MAX)) begin
        done_count <= done_count + DONE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tuser <= {done_now, ran};
      m_tdata <= {{(MDATA_W - IDX_W - 3 * CLK_W - 1){1'b0}},
                  tick_clock,
                  all_done,
                  done_now ? wait_time : {CLK_W{1'b0}},
                  done_now ? fin_time : {CLK_W{1'b0}},
                  ran ? IDX_W'(fin_pick) : {IDX_W{1'b0}}};
    end
  end

  // ---------------- checks ----------------
  `PPS_ASSERT_IMP(a_one_token, clk, rst, 1'b1, $onehot0(token_vec))
  `PPS_ASSERT_NXT(a_scan_to_out, clk, rst, (state == S_SCAN) && last_valid,
                  state == S_OUT)
  `PPS_ASSERT_IMP(a_done_after_run, clk, rst, m_tvalid && m_tdata[68] && m_tuser[0],
                  m_tuser[1])
  `PPS_ASSERT_IMP(a_finish_nonzero, clk, rst, m_tvalid && m_tuser[1],
                  m_tuser[0] && (m_tdata[35:4] != '0))

endmodule

`default_nettype wire

[sim/preemptive_priority_scheduler_unit_test.sv]
// Self-checking bench for preemptive_priority_scheduler_unit: loads and ticks go in,
// and every result is checked against a scheduler model kept in the bench.
// Depends on pps_pkg and the scheduler RTL only.
`timescale 1ns / 1ps

module preemptive_priority_scheduler_unit_test;
  import pps_pkg::*;

  localparam int MAX_TASKS     = DEFAULT_MAX_TASKS;
  localparam int SETTLE_CYCLES = 40;
  localparam int SHOW_LIMIT    = 20;
  localparam int LONG_HOLD     = 300;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  idx;
    logic [WORK_W-1:0] burst;
    logic [PRI_W-1:0]  pri;
  } sched_item_t;

  typedef struct packed {
    logic              run_valid;
    logic [IDX_W-1:0]  run_index;
    logic              finished;
    logic [CLK_W-1:0]  turnaround;
    logic [CLK_W-1:0]  waiting;
    logic              all_done;
    logic [CLK_W-1:0]  time_now;
  } sched_result_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [TCNT_W-1:0]   cfg_wr_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [SDATA_W-1:0]  s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [MDATA_W-1:0]  m_tdata;
  logic [MUSER_W-1:0]  m_tuser;

  // scheduler model state
  logic [WORK_W-1:0]   work_left [MAX_TASKS];
  logic [PRI_W-1:0]    pri_tab [MAX_TASKS];
  logic [WORK_W-1:0]   burst_tab [MAX_TASKS];
  logic [CLK_W-1:0]    sched_clock = '0;
  logic [TCNT_W-1:0]   task_count_q = TASK_COUNT_RESET;

  sched_item_t         item_q [$];
  sched_result_t       expected_q [$];
  sched_item_t         cur_item;
  sched_result_t       want;
  logic                took_item = 1'b0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int recv_hold_left = 0;
  int mismatches     = 0;
  int n_sent         = 0;
  int n_checked      = 0;
  int n_finished     = 0;
  int n_idle_ticks   = 0;

  int cfg_plan [10] = '{16, 31, 4, 1, 16, 0, 9, 2, 17, 16};

  preemptive_priority_scheduler_unit #(
    .MAX_TASKS(MAX_TASKS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      work_left[i] = '0;
      pri_tab[i]   = '0;
      burst_tab[i] = '0;
    end
  end

  function automatic int entries_in_use();
    return (task_count_q > MAX_TASKS) ? MAX_TASKS : int'(task_count_q);
  endfunction

  function automatic logic none_pending();
    logic all_idle;
    all_idle = 1'b1;
    for (int i = 0; i < entries_in_use(); i++)
      if (work_left[i] != 0) all_idle = 1'b0;
    return all_idle;
  endfunction

  // Apply one item to the model and return the result the block must produce.
  function automatic sched_result_t schedule_one(input sched_item_t it);
    sched_result_t     r;
    logic              found;
    logic [PRI_W-1:0]  best;
    int                pick;
    logic [CLK_W-1:0]  fin;
    r = '0;
    if (it.op == OP_LOAD) begin
      burst_tab[it.idx] = it.burst;
      pri_tab[it.idx]   = it.pri;
      work_left[it.idx] = it.burst;
      sched_clock = '0;
      r.all_done = none_pending();
      return r;
    end
    r.time_now = sched_clock;
    found = 1'b0;
    best  = '0;
    pick  = 0;
    // strict compare keeps ties on the lowest index
    for (int i = 0; i < entries_in_use(); i++) begin
      if (work_left[i] != 0 && (!found || pri_tab[i] > best)) begin
        found = 1'b1;
        best  = pri_tab[i];
        pick  = i;
      end
    end
    if (found) begin
      r.run_valid = 1'b1;
      r.run_index = IDX_W'(pick);
      work_left[pick] = work_left[pick] - 1'b1;
      if (work_left[pick] == 0) begin
        fin = (sched_clock == CLOCK_MAX) ? CLOCK_MAX : sched_clock + 1;
        r.finished   = 1'b1;
        r.turnaround = fin;
        // clock cleared mid-task: clamp waiting at zero
        r.waiting    = (fin >= CLK_W'(burst_tab[pick])) ? fin - CLK_W'(burst_tab[pick]) : '0;
        n_finished++;
      end
    end else begin
      n_idle_ticks++;
    end
    if (sched_clock != CLOCK_MAX) sched_clock = sched_clock + 1;
    r.all_done = none_pending();
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [CLK_W-1:0] got,
                                 input logic [CLK_W-1:0] exp_val);
    mismatches++;
    if (mismatches <= SHOW_LIMIT)
      $display("MISMATCH at result %0d: %s got 0x%0h, want 0x%0h", n_checked, what, got,
               exp_val);
  endtask

  // Input side: present the next pending item once the previous one is taken.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= 1'b0;
    end else if (!s_tvalid || took_item) begin
      took_item = 1'b0;
      if (item_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_item = item_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {{(SDATA_W - IDX_W - WORK_W - PRI_W){1'b0}},
                     cur_item.pri, cur_item.burst, cur_item.idx};
        s_tuser  <= cur_item.op;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      expected_q.push_back(schedule_one(cur_item));
      took_item = 1'b1;
      n_sent++;
    end
  end

  // Output side: random stalls, plus a long hold when requested.
  always @(negedge clk) begin
    if (recv_hold_left > 0) begin
      recv_hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing pending", 0, 0);
      end else begin
        want = expected_q.pop_front();
        if (m_tuser[0] !== want.run_valid)
          report_mismatch("run_valid", m_tuser[0], want.run_valid);
        if (m_tdata[3:0] !== want.run_index)
          report_mismatch("run_index", m_tdata[3:0], want.run_index);
        if (m_tuser[1] !== want.finished)
          report_mismatch("finished", m_tuser[1], want.finished);
        if (m_tdata[35:4] !== want.turnaround)
          report_mismatch("turnaround", m_tdata[35:4], want.turnaround);
        if (m_tdata[67:36] !== want.waiting)
          report_mismatch("waiting", m_tdata[67:36], want.waiting);
        if (m_tdata[68] !== want.all_done)
          report_mismatch("all_done", m_tdata[68], want.all_done);
        if (m_tdata[100:69] !== want.time_now)
          report_mismatch("time_now", m_tdata[100:69], want.time_now);
      end
      n_checked++;
    end
  end

  task automatic push_item(input op_t op, input int idx, input int burst, input int pri);
    sched_item_t it;
    it.op    = op;
    it.idx   = IDX_W'(idx);
    it.burst = WORK_W'(burst);
    it.pri   = PRI_W'(pri);
    item_q.push_back(it);
  endtask

  task automatic push_ticks(input int count);
    for (int k = 0; k < count; k++) push_item(OP_TICK, 0, 0, 0);
  endtask

  task automatic write_task_count(input logic [TCNT_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    task_count_q = value;
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;  recv_stall_pct = 0;
      end
      IDLE_SEND: begin
        send_idle_pct = 86; recv_stall_pct = 0;
      end
      IDLE_RECV: begin
        send_idle_pct = 0;  recv_stall_pct = 86;
      end
      default: begin
        send_idle_pct = 32; recv_stall_pct = 32;
      end
    endcase
  endtask

  // Hold off until every item is taken and every result is back.
  task automatic drain();
    while (item_q.size() != 0 || s_tvalid || expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly load-then-run sequences with small bursts, mixed with raw noise items.
  task automatic add_random_items(input int target);
    int start_size, n, rot, ticks, extra, mid, burst, pri, tie_mode;
    start_size = item_q.size();
    while (item_q.size() - start_size < target) begin
      if ($urandom_range(99) < 75) begin
        n = entries_in_use();
        if (n == 0) n = $urandom_range(4, 1);
        rot = $urandom_range(n - 1);
        tie_mode = ($urandom_range(2) == 0);
        ticks = 0;
        for (int k = 0; k < n; k++) begin
          burst = ($urandom_range(9) == 0) ? 0 : $urandom_range(6, 1);
          pri = tie_mode ? $urandom_range(3) : $urandom_range(255);
          push_item(OP_LOAD, (k + rot) % n, burst, pri);
          ticks += burst;
        end
        ticks += $urandom_range(3);
        mid = ($urandom_range(2) == 0) ? $urandom_range(ticks) : -1;
        extra = 0;
        for (int t = 0; t < ticks; t++) begin
          // a fresh arrival mid-run may preempt the running entry
          if (t == mid) begin
            burst = $urandom_range(4, 1);
            push_item(OP_LOAD, $urandom_range(n - 1), burst, $urandom_range(255));
            extra = burst;
          end
          push_ticks(1);
        end
        push_ticks(extra);
      end else begin
        push_item(op_t'($urandom_range(1)), $urandom_range(15), $urandom_range(65535),
                  $urandom_range(255));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset count of one: idle ticks, priority zero winning, entry beyond count.
    set_idling(IDLE_NONE);
    push_ticks(1);
    push_item(OP_LOAD, 0, 2, 0);
    push_ticks(2);
    push_item(OP_LOAD, 15, 16'hFFFF, 8'hFF);
    push_ticks(1);
    drain();

    // Full table: top priority, tie to the lower index, zero burst, clock
    // cleared while a task is part done.
    write_task_count(16);
    push_item(OP_LOAD, 15, 1, 255);
    push_item(OP_LOAD, 3, 3, 5);
    push_item(OP_LOAD, 5, 2, 5);
    push_item(OP_LOAD, 7, 0, 255);
    push_ticks(7);
    push_item(OP_LOAD, 2, 5, 10);
    push_ticks(3);
    push_item(OP_LOAD, 4, 1, 1);
    push_ticks(3);
    drain();

    // No entry in use.
    write_task_count(0);
    push_item(OP_LOAD, 0, 3, 9);
    push_ticks(2);
    drain();

    for (int p = 0; p < 10; p++) begin
      write_task_count(TCNT_W'(cfg_plan[p]));
      set_idling(idle_mode_t'(p % 4));
      add_random_items(cfg_plan[p] == 0 ? 30 : 120);
      if (p == 0) begin
        @(posedge clk);
        recv_hold_left = LONG_HOLD;
      end
      drain();
    end

    if (expected_q.size() != 0)
      report_mismatch("results never delivered", expected_q.size(), 0);
    $display("run summary: %0d items in, %0d results checked, %0d mismatches",
             n_sent, n_checked, mismatches);
    $display("task completions %0d, idle ticks %0d, task_count settings 0 to 31",
             n_finished, n_idle_ticks);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout: scheduler stopped making progress");
    $display("status: fail");
    $finish;
  end

endmodule
